// ===== hdl/iqm_pkg.sv =====
`timescale 1ns / 1ps

package iqm_pkg;

  // Operating mode, as held in the configuration register.
  typedef enum logic {
    MODE_REAL    = 1'b0,
    MODE_COMPLEX = 1'b1
  } iqm_mode_e;

  localparam iqm_mode_e MODE_RST = MODE_COMPLEX;

  // Control that travels with every pipeline stage.
  typedef struct packed {
    logic      valid;
    iqm_mode_e mode;
  } iqm_ctl_t;

  localparam iqm_ctl_t CTL_EMPTY = '{valid: 1'b0, mode: MODE_RST};

endpackage

// ===== hdl/iqm_ifs.sv =====
`timescale 1ns / 1ps

// Sample pair channel
interface iqm_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_phase;
  logic signed [SAMPLE_BITS-1:0] quadrature;

  modport source (output valid, output in_phase, output quadrature, input ready);
  modport sink   (input valid, input in_phase, input quadrature, output ready);
endinterface

// Result channel
interface iqm_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] result_sample;

  modport source (output valid, output result_sample, input ready);
  modport sink   (input valid, input result_sample, output ready);
endinterface

// Configuration write channel
interface iqm_cfg_if;
  logic valid;
  logic ready;
  logic complex_mode;

  modport source (output valid, output complex_mode, input ready);
  modport sink   (input valid, input complex_mode, output ready);
endinterface

// ===== hdl/iqm_square.sv =====
`timescale 1ns / 1ps

// Stage 1: absolute values and squares of both parts.
module iqm_square #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  iqm_pkg::iqm_ctl_t             ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] in_phase_i,
  input  logic signed [SAMPLE_BITS-1:0] quadrature_i,
  output logic                          ready_o,
  output iqm_pkg::iqm_ctl_t             ctl_o,
  output logic [SAMPLE_BITS-1:0]        sample_o,
  output logic [2*SAMPLE_BITS-1:0]      sq_a_o,
  output logic [2*SAMPLE_BITS-1:0]      sq_b_o,
  input  logic                          down_ready_i
);
  import iqm_pkg::*;

  localparam int RW = 2 * SAMPLE_BITS;

  iqm_ctl_t               ctl_q;
  logic [SAMPLE_BITS-1:0] abs_a, abs_b;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [RW-1:0]          sq_a_d, sq_b_d, sq_a_q, sq_b_q;

  // most negative value maps to 2^(W-1), which still fits unsigned
  assign abs_a  = in_phase_i[SAMPLE_BITS-1]   ? (~in_phase_i + 1'b1)   : in_phase_i;
  assign abs_b  = quadrature_i[SAMPLE_BITS-1] ? (~quadrature_i + 1'b1) : quadrature_i;
  assign sq_a_d = RW'(abs_a) * RW'(abs_a);
  assign sq_b_d = RW'(abs_b) * RW'(abs_b);

  assign ready_o = !ctl_q.valid || down_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= CTL_EMPTY;
    end else if (ready_o) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ctl_i.valid) begin
      sample_q <= in_phase_i;
      sq_a_q   <= sq_a_d;
      sq_b_q   <= sq_b_d;
    end
  end

  assign ctl_o    = ctl_q;
  assign sample_o = sample_q;
  assign sq_a_o   = sq_a_q;
  assign sq_b_o   = sq_b_q;

endmodule

// ===== hdl/iqm_sum_sat.sv =====
`timescale 1ns / 1ps

// Stage 2: add the squares and clamp to 2^(2W-2)-1.
module iqm_sum_sat #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  iqm_pkg::iqm_ctl_t        ctl_i,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  logic [2*SAMPLE_BITS-1:0] sq_a_i,
  input  logic [2*SAMPLE_BITS-1:0] sq_b_i,
  output logic                     ready_o,
  output iqm_pkg::iqm_ctl_t        ctl_o,
  output logic [SAMPLE_BITS-1:0]   sample_o,
  output logic [2*SAMPLE_BITS-1:0] rem_o,
  input  logic                     down_ready_i
);
  import iqm_pkg::*;

  localparam int            RW      = 2 * SAMPLE_BITS;
  localparam logic [RW:0]   LIMIT_W = {3'b000, {(RW - 2){1'b1}}};
  localparam logic [RW-1:0] LIMIT   = {2'b00, {(RW - 2){1'b1}}};

  iqm_ctl_t               ctl_q;
  logic [RW:0]            sum;
  logic [RW-1:0]          rem_d, rem_q;
  logic [SAMPLE_BITS-1:0] sample_q;

  assign sum   = {1'b0, sq_a_i} + {1'b0, sq_b_i};
  assign rem_d = (sum > LIMIT_W) ? LIMIT : sum[RW-1:0];

  assign ready_o = !ctl_q.valid || down_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= CTL_EMPTY;
    end else if (ready_o) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ctl_i.valid) begin
      sample_q <= sample_i;
      rem_q    <= rem_d;
    end
  end

  assign ctl_o    = ctl_q;
  assign sample_o = sample_q;
  assign rem_o    = rem_q;

endmodule

// ===== hdl/iqm_root_step.sv =====
`timescale 1ns / 1ps

// One restoring bit-pair step of the square root; STEP picks the bit pair.
module iqm_root_step #(
  parameter int SAMPLE_BITS = 16,
  parameter int STEP        = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  iqm_pkg::iqm_ctl_t        ctl_i,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  logic [2*SAMPLE_BITS-1:0] rem_i,
  input  logic [2*SAMPLE_BITS-1:0] root_i,
  output logic                     ready_o,
  output iqm_pkg::iqm_ctl_t        ctl_o,
  output logic [SAMPLE_BITS-1:0]   sample_o,
  output logic [2*SAMPLE_BITS-1:0] rem_o,
  output logic [2*SAMPLE_BITS-1:0] root_o,
  input  logic                     down_ready_i
);
  import iqm_pkg::*;

  localparam int            RW     = 2 * SAMPLE_BITS;
  localparam int            BITPOS = RW - 2 - 2 * STEP;
  localparam logic [RW-1:0] BIT_C  = {{(RW - 1){1'b0}}, 1'b1} << BITPOS;

  iqm_ctl_t               ctl_q;
  logic [RW-1:0]          trial;
  logic                   take;
  logic [RW-1:0]          rem_d, rem_q, root_d, root_q;
  logic [SAMPLE_BITS-1:0] sample_q;

  assign trial  = root_i + BIT_C;
  assign take   = (rem_i >= trial);
  assign rem_d  = take ? (rem_i - trial) : rem_i;
  assign root_d = (take ? (root_i + (BIT_C << 1)) : root_i) >> 1;

  assign ready_o = !ctl_q.valid || down_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= CTL_EMPTY;
    end else if (ready_o) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ctl_i.valid) begin
      sample_q <= sample_i;
      rem_q    <= rem_d;
      root_q   <= root_d;
    end
  end

  assign ctl_o    = ctl_q;
  assign sample_o = sample_q;
  assign rem_o    = rem_q;
  assign root_o   = root_q;

endmodule

// ===== hdl/iq_to_magnitude_top.sv =====
`timescale 1ns / 1ps

// Complex magnitude of signed I/Q sample pairs. With complex_mode set (the
// reset value) each pair (I, Q) yields floor(sqrt(min(I*I + Q*Q,
// 2^(2*SAMPLE_BITS-2)-1))), a value from 0 to 2^(SAMPLE_BITS-1)-1; the sum
// is formed at full width, so even the most negative samples clamp cleanly
// to the top code. With complex_mode clear the in-phase sample is copied
// out and quadrature is ignored. Throughput is one pair per clock while
// the result side accepts results. In the register chain one stage
// squares, one adds and clamps, then SAMPLE_BITS-1 stages each
// resolve one root bit. Each stage holds its item until the next stage can
// take it, so back-pressure on the result side stalls the pipe without loss
// and input keeps flowing into empty slots. Write complex_mode only while
// no item is in flight.
module iq_to_magnitude_top #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  iqm_cfg_if.sink    cfg_i,
  iqm_in_if.sink     in_i,
  iqm_out_if.source  out_o
);
  import iqm_pkg::*;

  localparam int RW    = 2 * SAMPLE_BITS;
  // root steps; the topmost bit pair can never be taken and is skipped
  localparam int NSTEP = SAMPLE_BITS - 1;

  // ---------------------------------------------------------------------
  // Configuration register (always ready)
  // ---------------------------------------------------------------------
  iqm_mode_e mode_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RST;
    end else if (cfg_i.valid) begin
      mode_q <= iqm_mode_e'(cfg_i.complex_mode);
    end
  end

  // ---------------------------------------------------------------------
  // Square stage
  // ---------------------------------------------------------------------
  iqm_ctl_t               ctl_in, ctl_sq;
  logic [SAMPLE_BITS-1:0] sample_sq;
  logic [RW-1:0]          sq_a, sq_b;
  logic                   ready_sum;

  assign ctl_in = '{valid: in_i.valid, mode: mode_q};

  iqm_square #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_square (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl_in),
    .in_phase_i   (in_i.in_phase),
    .quadrature_i (in_i.quadrature),
    .ready_o      (in_i.ready),
    .ctl_o        (ctl_sq),
    .sample_o     (sample_sq),
    .sq_a_o       (sq_a),
    .sq_b_o       (sq_b),
    .down_ready_i (ready_sum)
  );

  // ---------------------------------------------------------------------
  // Sum and clamp; feeds slot 0 of the root chain
  // ---------------------------------------------------------------------
  iqm_ctl_t               ctl_s    [NSTEP+1];
  logic [SAMPLE_BITS-1:0] sample_s [NSTEP+1];
  logic [RW-1:0]          rem_s    [NSTEP+1];
  logic [RW-1:0]          root_s   [NSTEP+1];
  logic                   ready_s  [NSTEP+1];

  iqm_sum_sat #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sum_sat (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl_sq),
    .sample_i     (sample_sq),
    .sq_a_i       (sq_a),
    .sq_b_i       (sq_b),
    .ready_o      (ready_sum),
    .ctl_o        (ctl_s[0]),
    .sample_o     (sample_s[0]),
    .rem_o        (rem_s[0]),
    .down_ready_i (ready_s[0])
  );

  assign root_s[0] = '0;

  // ---------------------------------------------------------------------
  // Root chain: one bit pair per stage
  // ---------------------------------------------------------------------
  for (genvar k = 1; k <= NSTEP; k++) begin : g_root
    iqm_root_step #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .STEP        (k)
    ) u_step (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl_s[k-1]),
      .sample_i     (sample_s[k-1]),
      .rem_i        (rem_s[k-1]),
      .root_i       (root_s[k-1]),
      .ready_o      (ready_s[k-1]),
      .ctl_o        (ctl_s[k]),
      .sample_o     (sample_s[k]),
      .rem_o        (rem_s[k]),
      .root_o       (root_s[k]),
      .down_ready_i (ready_s[k])
    );
  end

  // ---------------------------------------------------------------------
  // Result: last stage register drives the port
  // ---------------------------------------------------------------------
  assign ready_s[NSTEP]      = out_o.ready;
  assign out_o.valid         = ctl_s[NSTEP].valid;
  assign out_o.result_sample = (ctl_s[NSTEP].mode == MODE_COMPLEX)
                               ? root_s[NSTEP][SAMPLE_BITS-1:0]
                               : sample_s[NSTEP];

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // magnitude is never negative
  a_mag_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && ctl_s[NSTEP].mode == MODE_COMPLEX)
      |-> !out_o.result_sample[SAMPLE_BITS-1])
    else $error("negative magnitude");

  // finished root is the floor: remainder x - r*r never exceeds 2r
  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_s[NSTEP].valid && ctl_s[NSTEP].mode == MODE_COMPLEX)
      |-> (rem_s[NSTEP] <= (root_s[NSTEP] << 1)))
    else $error("root remainder out of range");

  // a config transfer lands in the mode register
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_i.valid && cfg_i.ready)
      |=> (mode_q == iqm_mode_e'($past(cfg_i.complex_mode))))
    else $error("mode register not updated");

endmodule
